// File: hw/rtl/tor_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tor_pkg: shared types, codes and reply tables of the telnet option responder
// Holds the telnet codes, the reply kinds, the command record passed from the
// front end to the reply engine, and the fixed reply tables.
// ----------------------------------------------------------------------------
package tor_pkg;

	// Telnet codes
	localparam logic [7:0] CODE_IAC  = 8'hFF;
	localparam logic [7:0] CODE_WILL = 8'hFB;
	localparam logic [7:0] CODE_DO   = 8'hFD;
	localparam logic [7:0] CODE_SB   = 8'hFA;
	localparam logic [7:0] CODE_SE   = 8'hF0;

	// Options with a dedicated reply
	localparam logic [7:0] OPT_TSPEED  = 8'd32;
	localparam logic [7:0] OPT_XDISP   = 8'd35;
	localparam logic [7:0] OPT_ENVIRON = 8'd39;
	localparam logic [7:0] OPT_TTYPE   = 8'd24;

	// Command grouping positions
	localparam logic [2:0] POS_LEAD   = 3'd0;
	localparam logic [2:0] POS_CMD    = 3'd1;
	localparam logic [2:0] POS_OPT    = 3'd2;
	localparam logic [2:0] POS_SB_END = 3'd5;

	// Command queue between front end and reply engine
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

	// Reply byte index, wide enough for the longest reply
	localparam int IDX_W = 5;

	typedef enum logic [2:0] {
		KIND_WILL,
		KIND_TSPEED,
		KIND_XDISP,
		KIND_NEWENV,
		KIND_TTYPE
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] option;
	} cmd_t;

	// Reply tables
	localparam logic [7:0] ROM_TSPEED [17] = '{
		8'hFF, 8'hFA, 8'h20, 8'h00, 8'h33, 8'h38, 8'h34, 8'h30, 8'h30, 8'h2C,
		8'h33, 8'h38, 8'h34, 8'h30, 8'h30, 8'hFF, 8'hF0
	};
	localparam logic [7:0] ROM_XDISP [13] = '{
		8'hFF, 8'hFA, 8'h23, 8'h00, 8'h67, 8'h61, 8'h68, 8'h3A, 8'h30, 8'h2E,
		8'h30, 8'hFF, 8'hF0
	};
	localparam logic [7:0] ROM_NEWENV [14] = '{
		8'hFF, 8'hFA, 8'h27, 8'h00, 8'h00, 8'h67, 8'h61, 8'h68, 8'h3A, 8'h30,
		8'h2E, 8'h30, 8'hFF, 8'hF0
	};
	localparam logic [7:0] ROM_TTYPE [11] = '{
		8'hFF, 8'hFA, 8'h18, 8'h00, 8'h78, 8'h74, 8'h65, 8'h72, 8'h6D, 8'hFF,
		8'hF0
	};

	// Pick the reply kind for the option of a DO command
	function automatic kind_t classify(input logic [7:0] option);
		kind_t k;
		case (option)
			OPT_TSPEED:  k = KIND_TSPEED;
			OPT_XDISP:   k = KIND_XDISP;
			OPT_ENVIRON: k = KIND_NEWENV;
			OPT_TTYPE:   k = KIND_TTYPE;
			default:     k = KIND_WILL;
		endcase
		return k;
	endfunction

	// Number of bytes in a reply
	function automatic logic [IDX_W-1:0] reply_len(input kind_t kind);
		logic [IDX_W-1:0] n;
		case (kind)
			KIND_TSPEED: n = IDX_W'(17);
			KIND_XDISP:  n = IDX_W'(13);
			KIND_NEWENV: n = IDX_W'(14);
			KIND_TTYPE:  n = IDX_W'(11);
			default:     n = IDX_W'(3);
		endcase
		return n;
	endfunction

	// Byte at a given index of a reply
	function automatic logic [7:0] reply_byte_at(input kind_t kind,
			input logic [7:0] option, input logic [IDX_W-1:0] idx);
		logic [7:0] b;
		b = 8'h00;
		case (kind)
			KIND_TSPEED: begin
				if (idx < IDX_W'(17)) b = ROM_TSPEED[idx];
			end
			KIND_XDISP: begin
				if (idx < IDX_W'(13)) b = ROM_XDISP[idx[3:0]];
			end
			KIND_NEWENV: begin
				if (idx < IDX_W'(14)) b = ROM_NEWENV[idx[3:0]];
			end
			KIND_TTYPE: begin
				if (idx < IDX_W'(11)) b = ROM_TTYPE[idx[3:0]];
			end
			default: begin
				if (idx == IDX_W'(0))      b = CODE_IAC;
				else if (idx == IDX_W'(1)) b = CODE_WILL;
				else                       b = option;
			end
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/tor_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tor_front: command grouping front end
// Groups payload bytes into three- or six-byte commands and hands each DO
// command, classified by option, to the command queue.
// ----------------------------------------------------------------------------
module tor_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic [7:0]    data_byte,
	input  wire logic          packet_start,
	output tor_pkg::cmd_t      cmd,
	output logic               cmd_valid
);

	logic [2:0] pos_q;
	logic [7:0] command_q;
	logic       skip_q;

	logic [2:0] pos_eff;
	logic       skip_eff;
	logic [2:0] pos_d;
	logic [7:0] command_d;
	logic       skip_d;
	logic       emit;

	// Work out the next grouping state for the incoming byte
	always_comb begin
		pos_eff   = packet_start ? tor_pkg::POS_LEAD : pos_q;
		skip_eff  = packet_start ? 1'b0 : skip_q;
		pos_d     = pos_eff;
		command_d = command_q;
		skip_d    = skip_eff;
		emit      = 1'b0;
		if (skip_eff) begin
			// drop the body of a subnegotiation
			if (pos_eff >= tor_pkg::POS_SB_END) begin
				pos_d  = tor_pkg::POS_LEAD;
				skip_d = 1'b0;
			end else begin
				pos_d = pos_eff + 3'd1;
			end
		end else if (pos_eff == tor_pkg::POS_LEAD) begin
			pos_d = tor_pkg::POS_CMD;
		end else if (pos_eff == tor_pkg::POS_CMD) begin
			command_d = data_byte;
			skip_d    = (data_byte == tor_pkg::CODE_SB);
			pos_d     = tor_pkg::POS_OPT;
		end else begin
			pos_d = tor_pkg::POS_LEAD;
			emit  = (command_q == tor_pkg::CODE_DO);
		end
	end

	// Hold the grouping state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= tor_pkg::POS_LEAD;
			command_q <= 8'h00;
			skip_q    <= 1'b0;
		end else if (accept) begin
			pos_q     <= pos_d;
			command_q <= command_d;
			skip_q    <= skip_d;
		end
	end

	// Classify the option of a finished DO command
	assign cmd_valid  = accept && emit;
	assign cmd.kind   = tor_pkg::classify(data_byte);
	assign cmd.option = data_byte;

endmodule
`default_nettype wire

// File: hw/rtl/tor_cmdq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tor_cmdq: command queue
// Short first-in first-out queue of classified commands between the front end
// and the reply engine, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module tor_cmdq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire tor_pkg::cmd_t wr_cmd,
	input  wire logic          rd_en,
	output tor_pkg::cmd_t      rd_cmd,
	output logic               full,
	output logic               empty
);

	tor_pkg::cmd_t                 slot_q [tor_pkg::CMDQ_DEPTH];
	logic [tor_pkg::CMDQ_AW-1:0]   wr_ptr_q;
	logic [tor_pkg::CMDQ_AW-1:0]   rd_ptr_q;
	logic [tor_pkg::CMDQ_AW:0]     count_q;

	logic do_wr;
	logic do_rd;

	assign full   = (count_q == (tor_pkg::CMDQ_AW+1)'(tor_pkg::CMDQ_DEPTH));
	assign empty  = (count_q == '0);
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_cmd = slot_q[rd_ptr_q];

	// Store commands
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + (tor_pkg::CMDQ_AW)'(1);
			if (do_rd) rd_ptr_q <= rd_ptr_q + (tor_pkg::CMDQ_AW)'(1);
			if (do_wr && !do_rd)      count_q <= count_q + (tor_pkg::CMDQ_AW+1)'(1);
			else if (do_rd && !do_wr) count_q <= count_q - (tor_pkg::CMDQ_AW+1)'(1);
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/tor_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tor_back: reply engine
// Takes commands from the queue and plays each reply, one byte per cycle while
// pop keeps up, into an output register read through an empty/pop interface.
// ----------------------------------------------------------------------------
module tor_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire tor_pkg::cmd_t cmd,
	input  wire logic          cmd_empty,
	output logic               cmd_pop,
	output logic [7:0]         reply_byte,
	output logic               reply_last,
	output logic               empty,
	input  wire logic          pop
);

	logic                      busy_q;
	tor_pkg::cmd_t             cur_q;
	logic [tor_pkg::IDX_W-1:0] idx_q;
	logic                      out_valid_q;
	logic [7:0]                out_byte_q;
	logic                      out_last_q;

	logic advance;
	logic at_last;

	assign advance = busy_q && (!out_valid_q || pop);
	assign at_last = (idx_q == tor_pkg::reply_len(cur_q.kind) - (tor_pkg::IDX_W)'(1));
	assign cmd_pop = !cmd_empty && (!busy_q || (advance && at_last));

	// Walk the current reply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (cmd_pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (advance) begin
			busy_q <= !at_last;
			idx_q  <= idx_q + (tor_pkg::IDX_W)'(1);
		end
	end

	// Hold the command being answered
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd;
		end
	end

	// Output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= tor_pkg::reply_byte_at(cur_q.kind, cur_q.option, idx_q);
			out_last_q <= at_last;
		end
	end

	assign empty      = !out_valid_q;
	assign reply_byte = out_byte_q;
	assign reply_last = out_last_q;

endmodule
`default_nettype wire

// File: hw/rtl/telnet_option_responder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// telnet_option_responder_unit: telnet option negotiation responder
// Groups received telnet payload bytes into commands and answers DO commands
// with fixed reply byte streams.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive data_byte and packet_start with push high; a beat is
//   taken at each edge where push is high and full is low. One byte per cycle
//   is taken while full stays low.
//   Result channel: while empty is low, reply_byte/reply_last show the oldest
//   reply byte; pop high at an edge takes it. reply_last marks a reply's end.
//   Reply path: a DO command goes through the queue and, once the engine is
//   idle, the command register; its 3 to 17 bytes enter the output register.
//   Replies stream one byte per cycle while pop stays high, back to back.
//   Buffering: one reply is played out while up to four classified commands
//   wait in the command queue; full rises when the queue holds four. A reply
//   can be far longer than the three bytes of its command, so input stalls
//   even with pop held high when long replies follow closely, and sooner
//   when the receiver holds off pop.
//   Reset: arst_n clears the grouping state, the queue and the output
//   register; no reply is pending afterwards.
// ----------------------------------------------------------------------------
module telnet_option_responder_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] data_byte,
	input  wire logic       packet_start,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      reply_byte,
	output logic            reply_last
);

	tor_pkg::cmd_t front_cmd;
	tor_pkg::cmd_t head_cmd;
	logic          front_valid;
	logic          q_empty;
	logic          q_pop;
	logic          accept;

	assign accept = push && !full;

	tor_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.data_byte    (data_byte),
		.packet_start (packet_start),
		.cmd          (front_cmd),
		.cmd_valid    (front_valid)
	);

	tor_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (front_valid),
		.wr_cmd (front_cmd),
		.rd_en  (q_pop),
		.rd_cmd (head_cmd),
		.full   (full),
		.empty  (q_empty)
	);

	tor_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (head_cmd),
		.cmd_empty  (q_empty),
		.cmd_pop    (q_pop),
		.reply_byte (reply_byte),
		.reply_last (reply_last),
		.empty      (empty),
		.pop        (pop)
	);

endmodule
`default_nettype wire

// File: hw/rtl/tor_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tor_chk: port checker for the telnet option responder
// Watches the result channel and checks the framing of each reply.
// ----------------------------------------------------------------------------
module tor_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       empty,
	input wire logic       pop,
	input wire logic [7:0] reply_byte,
	input wire logic       reply_last
);

	// Position of the shown byte within its reply, saturating at three
	logic [1:0] pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 2'd0;
		end else if (pop && !empty) begin
			if (reply_last)          pos_q <= 2'd0;
			else if (pos_q != 2'd3)  pos_q <= pos_q + 2'd1;
		end
	end

	// Hold a stalled result beat
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(reply_byte) && $stable(reply_last)))
		else $error("result beat changed while stalled");

	// Open every reply with IAC
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pos_q == 2'd0) |-> (reply_byte == tor_pkg::CODE_IAC))
		else $error("reply does not open with IAC");

	// Follow IAC with SB or WILL
	a_second: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pos_q == 2'd1) |->
		(reply_byte == tor_pkg::CODE_SB || reply_byte == tor_pkg::CODE_WILL))
		else $error("second reply byte is neither SB nor WILL");

	// Keep every reply at least three bytes long
	a_short: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (pos_q == 2'd0 || pos_q == 2'd1)) |-> !reply_last)
		else $error("reply ended too early");

endmodule

bind telnet_option_responder_unit tor_chk u_tor_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.reply_byte (reply_byte),
	.reply_last (reply_last)
);
`default_nettype wire
